// ===== rtl/pal_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the positional array list core.
// Used by pal_cell, pal_find_tree and positional_array_list_core; depends on nothing.
package pal_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W = 2;
    localparam int POS_W = 13;
    localparam int VAL_W = 32;
    localparam int POL_W = 2;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_FIRST = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_LAST  = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [POL_W-1:0] POLICY_FRONT = 2'd1;
    localparam logic [POL_W-1:0] POLICY_END   = 2'd2;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic             srch;
        logic [POS_W-1:0] slot;
        logic [POS_W-1:0] count;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] idx;
    } t_hit;

endpackage

// ===== rtl/pal_cell.sv =====
`timescale 1ns / 1ps
// One list cell: holds a single entry, shifts toward or away from its neighbors,
// and registers whether it matches a search target. Depends on pal_pkg.
module pal_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  pal_pkg::t_cell_ctl          i_ctl,
    input  logic [pal_pkg::VAL_W-1:0]   i_prev,
    input  logic [pal_pkg::VAL_W-1:0]   i_next,
    output logic [pal_pkg::VAL_W-1:0]   o_data,
    output logic                        o_match
);

    localparam logic [pal_pkg::POS_W-1:0] MY_IDX = pal_pkg::POS_W'(IDX);

    logic [pal_pkg::VAL_W-1:0] r_data;
    logic [pal_pkg::VAL_W-1:0] n_data;
    logic                      r_match;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX > i_ctl.slot) begin
                n_data = i_prev;
            end else if (MY_IDX == i_ctl.slot) begin
                n_data = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_ctl.slot) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.srch) begin
            r_match <= (r_data == i_ctl.value) && (MY_IDX < i_ctl.count);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// ===== rtl/pal_find_tree.sv =====
`timescale 1ns / 1ps
// Registered reduction tree that picks the first or last set match bit of the
// cell row, one tree level per clock. Depends on pal_pkg.
module pal_find_tree #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic [CAPACITY-1:0]  i_match,
    input  logic                 i_last,
    output pal_pkg::t_hit        o_root
);

    localparam int LVL = $clog2(CAPACITY);
    localparam int NP  = 1 << LVL;

    pal_pkg::t_hit r_node [NP-1];
    pal_pkg::t_hit w_all  [2*NP-1];

    function automatic pal_pkg::t_hit pick(
        input pal_pkg::t_hit a,
        input pal_pkg::t_hit b,
        input logic          last
    );
        pal_pkg::t_hit res;
        if (last) begin
            res = b.found ? b : a;
        end else begin
            res = a.found ? a : b;
        end
        return res;
    endfunction

    genvar g;
    generate
        for (g = 0; g < NP - 1; g++) begin : g_inner
            assign w_all[g] = r_node[g];
            always_ff @(posedge i_clk) begin
                r_node[g] <= pick(w_all[2*g+1], w_all[2*g+2], i_last);
            end
        end
        for (g = 0; g < NP; g++) begin : g_leaf
            if (g < CAPACITY) begin : g_real
                assign w_all[NP-1+g] = {i_match[g], pal_pkg::POS_W'(g)};
            end else begin : g_pad
                assign w_all[NP-1+g] = {1'b0, pal_pkg::POS_W'(g)};
            end
        end
    endgenerate

    assign o_root = r_node[0];

endmodule

// ===== rtl/positional_array_list_core.sv =====
`timescale 1ns / 1ps
// Top level of the positional array list: command decode, row of cells, search tree.
// Depends on pal_pkg, pal_cell and pal_find_tree.
//
// The list lives in a row of CAPACITY cells, one entry each, so an insert or a
// delete shifts every later entry at once; a request of either kind stalls the
// block until its result enters the output register. A search registers one
// match bit per cell and reduces them through a registered tree of
// $clog2(CAPACITY) levels before its result enters the output register.
// The result register lets the next request be taken while a result still waits.
module positional_array_list_core #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [pal_pkg::CMD_W-1:0]          i_command,
    input  logic [pal_pkg::POS_W-1:0]          i_position,
    input  logic signed [pal_pkg::VAL_W-1:0]   i_value,
    input  logic [pal_pkg::POL_W-1:0]          i_range_policy,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [pal_pkg::ST_W-1:0]           o_status,
    output logic [pal_pkg::POS_W-1:0]          o_found_position,
    output logic [pal_pkg::POS_W-1:0]          o_list_length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LVL   = $clog2(CAPACITY);
    localparam int WT_W  = $clog2(LVL + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_PEND   = 2'd2;

    logic [1:0]                  r_state;
    logic [CNT_W-1:0]            r_count;
    logic [WT_W-1:0]             r_wait;
    logic                        r_last;
    logic [pal_pkg::ST_W-1:0]    r_res_status;
    logic [pal_pkg::POS_W-1:0]   r_res_found;
    logic                        r_out_valid;
    logic [pal_pkg::ST_W-1:0]    r_status;
    logic [pal_pkg::POS_W-1:0]   r_found;
    logic [pal_pkg::POS_W-1:0]   r_length;

    logic                        w_accept;
    logic [pal_pkg::POS_W-1:0]   w_count;
    logic                        w_in_range;
    logic                        w_full;
    logic                        w_ins_ok;
    logic [pal_pkg::POS_W-1:0]   w_ins_slot;
    logic [pal_pkg::ST_W-1:0]    w_status;
    logic                        w_out_free;
    pal_pkg::t_cell_ctl          w_ctl;
    pal_pkg::t_hit               w_root;

    logic [pal_pkg::VAL_W-1:0]   w_data  [CAPACITY];
    logic [CAPACITY-1:0]         w_match;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_count    = pal_pkg::POS_W'(r_count);
    assign w_in_range = (i_position != '0) && (i_position <= w_count);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        w_ins_ok   = 1'b1;
        w_ins_slot = i_position - pal_pkg::POS_W'(1);
        w_status   = pal_pkg::ST_DONE;
        if (!w_in_range) begin
            if (i_range_policy == pal_pkg::POLICY_FRONT) begin
                w_ins_slot = '0;
            end else if (i_range_policy == pal_pkg::POLICY_END) begin
                w_ins_slot = w_count;
            end else begin
                w_ins_ok = 1'b0;
            end
        end
        unique case (i_command)
            pal_pkg::CMD_INSERT: begin
                if (!w_ins_ok) begin
                    w_status = pal_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = pal_pkg::ST_FULL;
                    w_ins_ok = 1'b0;
                end
            end
            pal_pkg::CMD_DELETE: begin
                if (!w_in_range) begin
                    w_status = pal_pkg::ST_RANGE;
                end
            end
            default: begin
                w_status = pal_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        w_ctl.ins   = w_accept && (i_command == pal_pkg::CMD_INSERT) && w_ins_ok;
        w_ctl.del   = w_accept && (i_command == pal_pkg::CMD_DELETE) && w_in_range;
        w_ctl.srch  = w_accept && ((i_command == pal_pkg::CMD_FIND_FIRST) ||
                                   (i_command == pal_pkg::CMD_FIND_LAST));
        w_ctl.slot  = (i_command == pal_pkg::CMD_DELETE) ?
                      (i_position - pal_pkg::POS_W'(1)) : w_ins_slot;
        w_ctl.count = w_count;
        w_ctl.value = i_value;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [pal_pkg::VAL_W-1:0] w_prev;
            logic [pal_pkg::VAL_W-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_prev
                assign w_prev = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_final
                assign w_next = '0;
            end else begin : g_mid_next
                assign w_next = w_data[g+1];
            end
            pal_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    pal_find_tree #(
        .CAPACITY (CAPACITY)
    ) u_tree (
        .i_clk   (i_clk),
        .i_match (w_match),
        .i_last  (r_last),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_status <= w_status;
                        r_res_found  <= '0;
                        r_wait       <= '0;
                        r_last       <= (i_command == pal_pkg::CMD_FIND_LAST);
                        if (w_ctl.ins) begin
                            r_count <= r_count + CNT_W'(1);
                        end else if (w_ctl.del) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                        r_state <= w_ctl.srch ? S_SEARCH : S_PEND;
                    end
                end
                S_SEARCH: begin
                    if (r_wait == WT_W'(LVL)) begin
                        r_res_found <= w_root.found ?
                                       (w_root.idx + pal_pkg::POS_W'(1)) : '0;
                        r_state     <= S_PEND;
                    end else begin
                        r_wait <= r_wait + WT_W'(1);
                    end
                end
                S_PEND: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if ((r_state == S_PEND) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_PEND) && w_out_free) begin
            r_status <= r_res_status;
            r_found  <= r_res_found;
            r_length <= w_count;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_list_length    = r_length;

endmodule
